// ----- rtl/core/pac_pkg.sv -----
// ----------------------------------------------------------------------------
// pac_pkg: shared constants and types for the polygon area/perimeter unit
// Field widths of the vertex and result items, and the control bundle
// that the sequencer hands to the shared multiply/root unit.
// ----------------------------------------------------------------------------
package pac_pkg;

    // Item field widths
    localparam int COORD_W    = 16;
    localparam int AREA_OUT_W = 44;
    localparam int PERIM_W    = 38;
    localparam int TOTAL_W    = 13;

    // Signed shoelace accumulator width (wraps modulo 2^45)
    localparam int AREA_ACC_W = 45;

    // Edge lengths carry this many fraction bits
    localparam int FRAC_BITS = 8;

    // Vertex counts at which each result becomes meaningful
    localparam int MIN_EDGE_PTS = 2;
    localparam int MIN_AREA_PTS = 3;
    localparam int MIN_TURN_PTS = 4;

    // Parameter defaults
    localparam int DEFAULT_MAX_VERTICES = 4096;
    localparam int DEFAULT_COORD_BITS   = 16;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic start;    // latch operands and begin
        logic sub;      // 1: a*b - c*d, 0: a*b + c*d
        logic root;     // follow with an integer square root
    } t_mac_ctl;

endpackage

// ----- rtl/core/pac_if.sv -----
// ----------------------------------------------------------------------------
// pac_if: valid/ready channels of the polygon area/perimeter unit
// Vertex channel in, result channel out.
// ----------------------------------------------------------------------------
interface pac_vertex_if;
    import pac_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      final_vertex;

    modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface pac_result_if;
    import pac_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [AREA_OUT_W-1:0] double_area;
    logic [PERIM_W-1:0]    perimeter_len;
    logic                  is_convex;
    logic [TOTAL_W-1:0]    vertex_total;
    logic                  count_overflow;

    modport source (output valid, double_area, perimeter_len, is_convex,
                    vertex_total, count_overflow, input ready);
    modport sink   (input valid, double_area, perimeter_len, is_convex,
                    vertex_total, count_overflow, output ready);
endinterface

// ----- rtl/core/pac_mac_sqrt.sv -----
// ----------------------------------------------------------------------------
// pac_mac_sqrt: shared multiply-accumulate and square-root unit
// Computes a*b -/+ c*d on one multiplier, the two products in turn, then optionally
// floor(sqrt(result * 2^(2*FRAC_BITS))) one root bit per cycle.
// ----------------------------------------------------------------------------
module pac_mac_sqrt #(
    parameter int COORD_BITS = pac_pkg::DEFAULT_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pac_pkg::t_mac_ctl            i_ctl,
    input  logic signed [COORD_BITS:0]   i_opa,
    input  logic signed [COORD_BITS:0]   i_opb,
    input  logic signed [COORD_BITS:0]   i_opc,
    input  logic signed [COORD_BITS:0]   i_opd,
    output logic                         o_done,
    output logic signed [2*COORD_BITS+2:0] o_acc,
    output logic [COORD_BITS+pac_pkg::FRAC_BITS:0] o_root
);
    import pac_pkg::*;

    localparam int OW   = COORD_BITS + 1;          // operand width
    localparam int PW   = 2 * OW;                  // product width
    localparam int AW   = PW + 1;                  // sum width
    localparam int RB   = COORD_BITS + FRAC_BITS + 1; // root bits
    localparam int RW   = 2 * RB;                  // radicand width
    localparam int REMW = RB + 3;                  // partial remainder width
    localparam int ITW  = $clog2(RB + 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL1,
        M_MUL2,
        M_ACC,
        M_LOAD,
        M_SQRT
    } t_mst;

    t_mst                  r_state;
    logic signed [OW-1:0]  r_a, r_b, r_c, r_d;
    logic                  r_sub;
    logic                  r_root_mode;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic [RW-1:0]         r_rad;
    logic [REMW-1:0]       r_rem;
    logic [RB-1:0]         r_sq;
    logic [ITW-1:0]        r_it;
    logic                  r_done;

    // Single shared multiplier, operands picked by phase
    logic signed [OW-1:0]  mul_x, mul_y;
    logic signed [PW-1:0]  mul_p;

    assign mul_x = (r_state == M_MUL1) ? r_a : r_c;
    assign mul_y = (r_state == M_MUL1) ? r_b : r_d;
    assign mul_p = mul_x * mul_y;

    // One restoring square-root step
    logic [REMW-1:0] n_rem_sh;
    logic [REMW-1:0] n_trial;
    logic            n_fits;

    assign n_rem_sh = {r_rem[REMW-3:0], r_rad[RW-1:RW-2]};
    assign n_trial  = REMW'({r_sq, 2'b01});
    assign n_fits   = (n_rem_sh >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_done      <= 1'b0;
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_d         <= '0;
            r_sub       <= 1'b0;
            r_root_mode <= 1'b0;
            r_prod      <= '0;
            r_acc       <= '0;
            r_rad       <= '0;
            r_rem       <= '0;
            r_sq        <= '0;
            r_it        <= '0;
        end else begin
            // pulse when the last step of a request completes
            r_done <= ((r_state == M_ACC) && !r_root_mode) ||
                      ((r_state == M_SQRT) && (r_it == ITW'(1)));
            case (r_state)
                M_IDLE: begin
                    if (i_ctl.start) begin
                        r_a         <= i_opa;
                        r_b         <= i_opb;
                        r_c         <= i_opc;
                        r_d         <= i_opd;
                        r_sub       <= i_ctl.sub;
                        r_root_mode <= i_ctl.root;
                        r_state     <= M_MUL1;
                    end
                end
                M_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= M_MUL2;
                end
                M_MUL2: begin
                    r_acc   <= AW'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= M_ACC;
                end
                M_ACC: begin
                    r_acc <= r_sub ? (r_acc - AW'(r_prod)) : (r_acc + AW'(r_prod));
                    if (r_root_mode) begin
                        r_state <= M_LOAD;
                    end else begin
                        r_state <= M_IDLE;
                    end
                end
                M_LOAD: begin
                    // radicand = d^2 scaled by 2^(2*FRAC_BITS)
                    r_rad   <= RW'({r_acc[AW-2:0], (2*FRAC_BITS)'(0)});
                    r_rem   <= '0;
                    r_sq    <= '0;
                    r_it    <= ITW'(RB);
                    r_state <= M_SQRT;
                end
                M_SQRT: begin
                    r_rad <= {r_rad[RW-3:0], 2'b00};
                    if (n_fits) begin
                        r_rem <= n_rem_sh - n_trial;
                        r_sq  <= {r_sq[RB-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sh;
                        r_sq  <= {r_sq[RB-2:0], 1'b0};
                    end
                    r_it <= r_it - ITW'(1);
                    if (r_it == ITW'(1)) begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_root = r_sq;

endmodule

// ----- rtl/core/polygon_area_perimeter_convexity_unit.sv -----
// ----------------------------------------------------------------------------
// polygon_area_perimeter_convexity_unit: shoelace area, perimeter, convexity
// Interior vertex: the turn term, the area term and then the edge length are
// computed, as the count allows, before ready returns; the edge root takes COORD_BITS+9 steps.
// Final vertex: then the closing edge, area term and two turns as the count
// allows, and then the result item is loaded; waits on a held item.
// Synchronous active-low reset clears all sums, flags and the vertex count.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_convexity_unit #(
    parameter int MAX_VERTICES = pac_pkg::DEFAULT_MAX_VERTICES,
    parameter int COORD_BITS   = pac_pkg::DEFAULT_COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pac_vertex_if.sink    i_vtx,
    pac_result_if.source  o_res
);
    import pac_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int OW    = CW + 1;
    localparam int AW    = 2 * OW + 1;
    localparam int RB    = CW + FRAC_BITS + 1;
    localparam int EXT_W = (CW > COORD_W) ? CW : COORD_W;
    localparam int CNTW  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_SHIFT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        J_TURN_QPN,
        J_AREA_PN,
        J_EDGE_PN,
        J_EDGE_PF,
        J_AREA_PF,
        J_TURN_QPF,
        J_TURN_PFS
    } t_job;

    t_state               r_state;
    t_job                 r_job;
    logic                 r_last;
    logic signed [CW-1:0] r_nx, r_ny;   // incoming vertex
    logic signed [CW-1:0] r_px, r_py;   // previous
    logic signed [CW-1:0] r_qx, r_qy;   // one before previous
    logic signed [CW-1:0] r_fx, r_fy;   // first
    logic signed [CW-1:0] r_sx, r_sy;   // second
    logic [CNTW-1:0]      r_cnt;
    logic                 r_ovf;
    logic [AREA_ACC_W-1:0] r_area;
    logic [PERIM_W-1:0]   r_edge;
    logic                 r_left;
    logic                 r_right;

    logic                  r_out_valid;
    logic [AREA_OUT_W-1:0] r_out_area;
    logic [PERIM_W-1:0]    r_out_perim;
    logic                  r_out_convex;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_ovf;

    // Coordinates: low CW bits of the field, zero-extended where CW exceeds the field
    logic [EXT_W-1:0] n_ext_x, n_ext_y;

    assign n_ext_x = EXT_W'($unsigned(i_vtx.vertex_x));
    assign n_ext_y = EXT_W'($unsigned(i_vtx.vertex_y));

    // Saturating vertex count after this vertex
    logic [CNTW-1:0] n_cnt;

    assign n_cnt = (r_cnt < CNTW'(MAX_VERTICES)) ? (r_cnt + CNTW'(1)) : r_cnt;

    // Job kind decode
    logic is_turn, is_area;

    assign is_turn = r_job inside {J_TURN_QPN, J_TURN_QPF, J_TURN_PFS};
    assign is_area = r_job inside {J_AREA_PN, J_AREA_PF};

    // Point selection and operand formation for the shared unit
    logic signed [CW-1:0] t0x, t0y, t1x, t1y, t2x, t2y;
    logic signed [OW-1:0] opa, opb, opc, opd;
    t_mac_ctl             mac_ctl;
    logic                 mac_done;
    logic signed [AW-1:0] mac_acc;
    logic [RB-1:0]        mac_root;

    always_comb begin
        t0x = r_qx;
        t0y = r_qy;
        t1x = r_px;
        t1y = r_py;
        t2x = r_nx;
        t2y = r_ny;
        case (r_job)
            J_TURN_QPF, J_AREA_PF, J_EDGE_PF: begin
                t2x = r_fx;
                t2y = r_fy;
            end
            J_TURN_PFS: begin
                t0x = r_px;
                t0y = r_py;
                t1x = r_fx;
                t1y = r_fy;
                t2x = r_sx;
                t2y = r_sy;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mac_ctl.start = (r_state == S_ISSUE);
        if (is_turn) begin
            // (p1-p0) x (p2-p1)
            opa          = OW'(t1x) - OW'(t0x);
            opb          = OW'(t2y) - OW'(t1y);
            opc          = OW'(t1y) - OW'(t0y);
            opd          = OW'(t2x) - OW'(t1x);
            mac_ctl.sub  = 1'b1;
            mac_ctl.root = 1'b0;
        end else if (is_area) begin
            // shoelace term a.x*b.y - b.x*a.y
            opa          = OW'(t1x);
            opb          = OW'(t2y);
            opc          = OW'(t2x);
            opd          = OW'(t1y);
            mac_ctl.sub  = 1'b1;
            mac_ctl.root = 1'b0;
        end else begin
            // squared edge length, then root
            opa          = OW'(t1x) - OW'(t2x);
            opb          = opa;
            opc          = OW'(t1y) - OW'(t2y);
            opd          = opc;
            mac_ctl.sub  = 1'b0;
            mac_ctl.root = 1'b1;
        end
    end

    pac_mac_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_opa   (opa),
        .i_opb   (opb),
        .i_opc   (opc),
        .i_opd   (opd),
        .o_done  (mac_done),
        .o_acc   (mac_acc),
        .o_root  (mac_root)
    );

    // Absolute value of the closed shoelace sum
    logic [AREA_ACC_W-1:0] n_abs;

    assign n_abs = r_area[AREA_ACC_W-1] ? (AREA_ACC_W'(0) - r_area) : r_area;

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_job        <= J_TURN_QPN;
            r_last       <= 1'b0;
            r_nx         <= '0;
            r_ny         <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_qx         <= '0;
            r_qy         <= '0;
            r_fx         <= '0;
            r_fy         <= '0;
            r_sx         <= '0;
            r_sy         <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_area       <= '0;
            r_edge       <= '0;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_area   <= '0;
            r_out_perim  <= '0;
            r_out_convex <= 1'b0;
            r_out_total  <= '0;
            r_out_ovf    <= 1'b0;
        end else begin
            // item taken and no new one loaded this cycle
            if (r_out_valid && o_res.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        r_nx   <= n_ext_x[CW-1:0];
                        r_ny   <= n_ext_y[CW-1:0];
                        r_last <= i_vtx.final_vertex;
                        if (r_cnt == '0) begin
                            r_state <= S_SHIFT;
                        end else if (r_cnt == CNTW'(1)) begin
                            r_job   <= J_AREA_PN;
                            r_state <= S_ISSUE;
                        end else begin
                            r_job   <= J_TURN_QPN;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mac_done) begin
                        // fold in the finished term
                        if (is_turn) begin
                            if (mac_acc < 0) begin
                                r_right <= 1'b1;
                            end
                            if (mac_acc > 0) begin
                                r_left <= 1'b1;
                            end
                        end else if (is_area) begin
                            r_area <= r_area + AREA_ACC_W'(mac_acc);
                        end else begin
                            r_edge <= r_edge + PERIM_W'(mac_root);
                        end
                        // pick the next job
                        case (r_job)
                            J_TURN_QPN: begin
                                r_job   <= J_AREA_PN;
                                r_state <= S_ISSUE;
                            end
                            J_AREA_PN: begin
                                r_job   <= J_EDGE_PN;
                                r_state <= S_ISSUE;
                            end
                            J_EDGE_PN: r_state <= S_SHIFT;
                            J_EDGE_PF: begin
                                if (r_cnt >= CNTW'(MIN_AREA_PTS)) begin
                                    r_job   <= J_AREA_PF;
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            J_AREA_PF: begin
                                if (r_cnt >= CNTW'(MIN_TURN_PTS)) begin
                                    r_job   <= J_TURN_QPF;
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            J_TURN_QPF: begin
                                r_job   <= J_TURN_PFS;
                                r_state <= S_ISSUE;
                            end
                            default:    r_state <= S_EMIT;
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_cnt == '0) begin
                        r_fx <= r_nx;
                        r_fy <= r_ny;
                    end
                    if (r_cnt == CNTW'(1)) begin
                        r_sx <= r_nx;
                        r_sy <= r_ny;
                    end
                    r_qx  <= r_px;
                    r_qy  <= r_py;
                    r_px  <= r_nx;
                    r_py  <= r_ny;
                    r_cnt <= n_cnt;
                    if (r_cnt == CNTW'(MAX_VERTICES)) begin
                        r_ovf <= 1'b1;
                    end
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (n_cnt >= CNTW'(MIN_EDGE_PTS)) begin
                        r_job   <= J_EDGE_PF;
                        r_state <= S_ISSUE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_area   <= (r_cnt >= CNTW'(MIN_AREA_PTS)) ?
                                        n_abs[AREA_OUT_W-1:0] : '0;
                        r_out_perim  <= (r_cnt >= CNTW'(MIN_EDGE_PTS)) ? r_edge : '0;
                        r_out_convex <= (r_cnt >= CNTW'(MIN_TURN_PTS)) ?
                                        !(r_left && r_right) : 1'b1;
                        r_out_total  <= TOTAL_W'(r_cnt);
                        r_out_ovf    <= r_ovf;
                        // back to the empty-polygon state
                        r_px    <= '0;
                        r_py    <= '0;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_fx    <= '0;
                        r_fy    <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_area  <= '0;
                        r_edge  <= '0;
                        r_left  <= 1'b0;
                        r_right <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign i_vtx.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.double_area    = r_out_area;
    assign o_res.perimeter_len  = r_out_perim;
    assign o_res.is_convex      = r_out_convex;
    assign o_res.vertex_total   = r_out_total;
    assign o_res.count_overflow = r_out_ovf;

    // Checks
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside of a wait");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_VERTICES))
        else $error("vertex count above limit");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == CNTW'(MAX_VERTICES)))
        else $error("overflow flag without saturated count");

    a_emit_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("pending result item dropped");

endmodule

// ----- dv/polygon_result_checker.sv -----
// ----------------------------------------------------------------------------
// polygon_result_checker: shoelace area / perimeter / convexity predictor
// Watches the vertex and result channels. Each accepted vertex updates a
// private copy of the polygon sums; a final vertex queues the expected item,
// and every accepted result item is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module polygon_result_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pac_vertex_if i_vtx,
    pac_result_if i_res,
    output int    o_mismatch_count,
    output int    o_outstanding
);
    import pac_pkg::*;

    typedef struct packed {
        logic [AREA_OUT_W-1:0] double_area;
        logic [PERIM_W-1:0]    perimeter_len;
        logic                  is_convex;
        logic [TOTAL_W-1:0]    vertex_total;
        logic                  count_overflow;
    } t_shape_result;

    // Predicted polygon state
    logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
    logic signed [COORD_W-1:0] last_x, last_y, older_x, older_y;
    logic [TOTAL_W-1:0]        seen_total;
    logic [AREA_ACC_W-1:0]     shoelace_acc;
    logic [PERIM_W-1:0]        perim_acc;
    logic                      turned_left, turned_right, saturated;

    t_shape_result             shapes_due[$];
    int                        bad_results = 0;

    assign o_mismatch_count = bad_results;

    // floor of the square root, two bits per step
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned rest, acc, probe;
        rest  = v;
        acc   = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (rest >= acc + probe) begin
                rest -= acc + probe;
                acc   = (acc >> 1) + probe;
            end else begin
                acc >>= 1;
            end
            probe >>= 2;
        end
        return acc;
    endfunction

    // edge length with FRAC_BITS fraction bits, truncated
    function automatic longint unsigned seg_length(input longint ax, input longint ay,
                                                   input longint bx, input longint by);
        longint dx, dy;
        longint unsigned d2;
        dx = ax - bx;
        dy = ay - by;
        d2 = longint'(dx * dx) + longint'(dy * dy);
        return root_floor(d2 << (2 * FRAC_BITS));
    endfunction

    function automatic longint cross_term(input longint ax, input longint ay,
                                          input longint bx, input longint by);
        return ax * by - bx * ay;
    endfunction

    // sign of the turn at (x1,y1)
    task automatic note_turn(input longint x0, input longint y0, input longint x1,
                             input longint y1, input longint x2, input longint y2);
        longint c;
        c = (x1 - x0) * (y2 - y1) - (y1 - y0) * (x2 - x1);
        if (c < 0) turned_right = 1'b1;
        if (c > 0) turned_left  = 1'b1;
    endtask

    task automatic clear_shape();
        first_x  = '0; first_y  = '0; second_x = '0; second_y = '0;
        last_x   = '0; last_y   = '0; older_x  = '0; older_y  = '0;
        seen_total   = '0;
        shoelace_acc = '0;
        perim_acc    = '0;
        turned_left  = 1'b0;
        turned_right = 1'b0;
        saturated    = 1'b0;
    endtask

    task automatic take_vertex(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py, input logic fin);
        t_shape_result         want;
        logic [AREA_ACC_W-1:0] mag;
        if (seen_total == 0) begin
            first_x = px;
            first_y = py;
        end else begin
            if (seen_total == 1) begin
                second_x = px;
                second_y = py;
            end else begin
                note_turn(older_x, older_y, last_x, last_y, px, py);
            end
            shoelace_acc += AREA_ACC_W'(cross_term(last_x, last_y, px, py));
            perim_acc    += PERIM_W'(seg_length(last_x, last_y, px, py));
        end
        older_x = last_x;
        older_y = last_y;
        last_x  = px;
        last_y  = py;

        if (seen_total < DEFAULT_MAX_VERTICES) seen_total++;
        else saturated = 1'b1;

        if (fin) begin
            want           = '0;
            want.is_convex = 1'b1;
            // closing edge back to the first vertex
            if (seen_total >= MIN_EDGE_PTS) begin
                perim_acc += PERIM_W'(seg_length(last_x, last_y, first_x, first_y));
                want.perimeter_len = perim_acc;
            end
            if (seen_total >= MIN_AREA_PTS) begin
                shoelace_acc += AREA_ACC_W'(cross_term(last_x, last_y, first_x, first_y));
                mag = shoelace_acc[AREA_ACC_W-1] ? (~shoelace_acc + 1'b1) : shoelace_acc;
                want.double_area = mag[AREA_OUT_W-1:0];
            end
            // wrap-around turns at the last and the first vertex
            if (seen_total >= MIN_TURN_PTS) begin
                note_turn(older_x, older_y, last_x, last_y, first_x, first_y);
                note_turn(last_x, last_y, first_x, first_y, second_x, second_y);
                want.is_convex = !(turned_left && turned_right);
            end
            want.vertex_total   = seen_total;
            want.count_overflow = saturated;
            shapes_due.push_back(want);
            clear_shape();
        end
    endtask

    task automatic check_result();
        t_shape_result want;
        logic          bad;
        if (shapes_due.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
                $display("unexpected result item: area=%0d perim=%0d convex=%0b total=%0d ovf=%0b",
                         i_res.double_area, i_res.perimeter_len, i_res.is_convex,
                         i_res.vertex_total, i_res.count_overflow);
            return;
        end
        want = shapes_due.pop_front();
        bad  = (i_res.double_area    !== want.double_area)   ||
               (i_res.perimeter_len  !== want.perimeter_len) ||
               (i_res.is_convex      !== want.is_convex)     ||
               (i_res.vertex_total   !== want.vertex_total)  ||
               (i_res.count_overflow !== want.count_overflow);
        if (bad) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("result mismatch: expected area=%0d perim=%0d convex=%0b total=%0d ovf=%0b",
                         want.double_area, want.perimeter_len, want.is_convex,
                         want.vertex_total, want.count_overflow);
                $display("                 actual   area=%0d perim=%0d convex=%0b total=%0d ovf=%0b",
                         i_res.double_area, i_res.perimeter_len, i_res.is_convex,
                         i_res.vertex_total, i_res.count_overflow);
            end
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shape();
            shapes_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) check_result();
            if (i_vtx.valid && i_vtx.ready)
                take_vertex(i_vtx.vertex_x, i_vtx.vertex_y, i_vtx.final_vertex);
        end
        o_outstanding <= shapes_due.size();
    end

endmodule

// ----- dv/polygon_area_perimeter_convexity_unit_tb.sv -----
// ----------------------------------------------------------------------------
// polygon_area_perimeter_convexity_unit_tb: stimulus and verdict
// Feeds directed polygons (single point, segment, extreme triangle and
// square, concave, degenerate, clockwise), then random polygons of mixed
// shapes and sizes, then one short polygon. Both channels stall at random;
// the checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_convexity_unit_tb;
    import pac_pkg::*;

    localparam int  RANDOM_ITEMS = 1520;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef enum int { SHAPE_WIDE, SHAPE_TIGHT, SHAPE_CORNER, SHAPE_BOX } t_shape_kind;

    logic   i_clk;
    logic   i_rst_n;
    logic   quiet;
    int     items_sent;
    longint cycle_count = 0;
    int     mismatch_count;
    int     outstanding;

    pac_vertex_if vtx_ch ();
    pac_result_if res_ch ();

    polygon_area_perimeter_convexity_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch)
    );

    polygon_result_checker checker_u (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vtx            (vtx_ch),
        .i_res            (res_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Result side back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_vertex(input int x, input int y, input bit fin);
        while (!quiet && $urandom_range(99) < 34) begin
            vtx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx_ch.valid        <= 1'b1;
        vtx_ch.vertex_x     <= COORD_W'(x);
        vtx_ch.vertex_y     <= COORD_W'(y);
        vtx_ch.final_vertex <= fin;
        @(posedge i_clk);
        while (!vtx_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold the vertex channel until every expected item has come back
    task automatic wait_results_drained();
        vtx_ch.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic int wide_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return wide_coord();
        endcase
    endfunction

    // Axis-aligned box, either winding, sometimes with a collinear midpoint
    task automatic send_box();
        int  xa, xb, ya, yb, lo_x, hi_x, lo_y, hi_y;
        bit  cw, mid;
        xa = wide_coord(); xb = wide_coord();
        ya = wide_coord(); yb = wide_coord();
        lo_x = (xa < xb) ? xa : xb;  hi_x = (xa < xb) ? xb : xa;
        lo_y = (ya < yb) ? ya : yb;  hi_y = (ya < yb) ? yb : ya;
        cw  = $urandom_range(1);
        mid = $urandom_range(1);
        push_vertex(lo_x, lo_y, 1'b0);
        if (!cw) begin
            if (mid) push_vertex((lo_x + hi_x) / 2, lo_y, 1'b0);
            push_vertex(hi_x, lo_y, 1'b0);
            push_vertex(hi_x, hi_y, 1'b0);
            push_vertex(lo_x, hi_y, 1'b1);
        end else begin
            if (mid) push_vertex(lo_x, (lo_y + hi_y) / 2, 1'b0);
            push_vertex(lo_x, hi_y, 1'b0);
            push_vertex(hi_x, hi_y, 1'b0);
            push_vertex(hi_x, lo_y, 1'b1);
        end
    endtask

    task automatic send_polygon(input int n, input t_shape_kind kind);
        int px, py;
        for (int k = 0; k < n; k++) begin
            case (kind)
                SHAPE_TIGHT: begin
                    px = int'($urandom_range(16)) - 8;
                    py = int'($urandom_range(16)) - 8;
                end
                SHAPE_CORNER: begin
                    px = corner_coord();
                    py = corner_coord();
                end
                default: begin
                    px = wide_coord();
                    py = wide_coord();
                end
            endcase
            push_vertex(px, py, k == n - 1);
        end
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return $urandom_range(3, 1);
        if (r < 85) return $urandom_range(10, 3);
        if (r < 97) return $urandom_range(30, 11);
        return $urandom_range(60, 31);
    endfunction

    initial begin
        t_shape_kind kind;
        int          random_start;

        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        quiet               = 1'b0;
        items_sent          = 0;
        vtx_ch.valid        = 1'b0;
        vtx_ch.vertex_x     = '0;
        vtx_ch.vertex_y     = '0;
        vtx_ch.final_vertex = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single vertex
        push_vertex(-32768, 32767, 1'b1);
        // segment between opposite extremes, counted there and back
        push_vertex(32767, -32768, 1'b0);
        push_vertex(-32768, 32767, 1'b1);
        // extreme triangle
        push_vertex(-32768, -32768, 1'b0);
        push_vertex(32767, -32768, 1'b0);
        push_vertex(32767, 32767, 1'b1);
        // full-range square, counter-clockwise
        push_vertex(-32768, -32768, 1'b0);
        push_vertex(32767, -32768, 1'b0);
        push_vertex(32767, 32767, 1'b0);
        push_vertex(-32768, 32767, 1'b1);
        // concave pentagon
        push_vertex(0, 0, 1'b0);
        push_vertex(10, 0, 1'b0);
        push_vertex(10, 10, 1'b0);
        push_vertex(5, 2, 1'b0);
        push_vertex(0, 10, 1'b1);
        // repeated point: zero area, zero turns
        repeat (3) push_vertex(3, 3, 1'b0);
        push_vertex(3, 3, 1'b1);
        // clockwise square: negative shoelace sum
        push_vertex(0, 0, 1'b0);
        push_vertex(0, 5, 1'b0);
        push_vertex(5, 5, 1'b0);
        push_vertex(5, 0, 1'b1);

        wait_results_drained();

        // Random polygons, with a stall-free stretch in the middle
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            quiet <= (items_sent - random_start >= 500) && (items_sent - random_start < 800);
            if (items_sent - random_start >= 900 && items_sent - random_start < 915)
                wait_results_drained();
            kind = t_shape_kind'($urandom_range(3));
            if (kind == SHAPE_BOX) send_box();
            else send_polygon(pick_size(), kind);
        end
        quiet <= 1'b0;

        // A short polygon at the end
        send_polygon(4, SHAPE_TIGHT);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
